/* design/lbc_pkg.sv */
// Shared types and constants for the LZW byte compressor.
// No dependencies; imported by every module of the block.
package lbc_pkg;

	localparam int BYTE_W        = 8;
	localparam int CODE_W        = 12;
	localparam int LIMIT_W       = 12;
	localparam int FIRST_FREE    = 256;
	localparam int OUT_TDATA_W   = 16;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;
	localparam int OFIFO_DEPTH   = 4;
	localparam int OFIFO_PTR_W   = 2;
	localparam int OFIFO_CNT_W   = 3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd4095;

	// Register index, taken from paddr[2]
	localparam logic REG_CODE_LIMIT = 1'b0;

	typedef struct packed {
		logic              eos;
		logic [CODE_W-1:0] code;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

endpackage

/* design/lbc_cell.sv */
// One cell of the dictionary search chain: a bank of dictionary entries,
// its compare against the search key and the registered hit hand-over.
// Depends on lbc_pkg.
module lbc_cell import lbc_pkg::*; #(
	parameter int CODE_BITS = 12,
	parameter int CELL_BITS = 4,
	parameter int CELL_IDX  = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  logic                           rd_en,
	input  logic [CODE_BITS-CELL_BITS-1:0] rd_row,
	input  logic                           wr_en,
	input  logic [CODE_BITS-CELL_BITS-1:0] wr_row,
	input  logic [CODE_BITS+BYTE_W-1:0]    wr_key,
	input  logic [CODE_BITS+BYTE_W-1:0]    key,
	input  logic [CODE_BITS:0]             nfc,
	input  logic                           hit_in,
	input  logic [CODE_BITS-1:0]           code_in,
	output logic                           hit_out,
	output logic [CODE_BITS-1:0]           code_out
);

	localparam int ROW_BITS = CODE_BITS - CELL_BITS;
	localparam int ROWS     = 1 << ROW_BITS;
	localparam int KEY_W    = CODE_BITS + BYTE_W;

	logic [KEY_W-1:0]     mem [ROWS];
	logic [KEY_W-1:0]     rdata_s1;
	logic [ROW_BITS-1:0]  row_s1;
	logic                 rd_s1;
	logic                 hit_q;
	logic [CODE_BITS-1:0] code_q;
	logic [CODE_BITS-1:0] entry_code;
	logic                 match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_key;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_row];
		end
		row_s1 <= rd_row;
	end

	assign entry_code = {row_s1, CELL_BITS'(CELL_IDX)};
	assign match = rd_s1 && (rdata_s1 == key) && ({1'b0, entry_code} < nfc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (clear) begin
				hit_q <= 1'b0;
			end else begin
				hit_q <= hit_q | hit_in | match;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_in) begin
			code_q <= code_in;
		end else if (match) begin
			code_q <= entry_code;
		end
	end

	assign hit_out  = hit_q;
	assign code_out = code_q;

endmodule

/* design/lbc_out_fifo.sv */
// Small result queue between the compressor core and the output stream.
// Depends on lbc_pkg.
module lbc_out_fifo import lbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  out_item_t              push_item,
	output logic                   room,
	output logic                   tvalid,
	input  logic                   tready,
	output out_item_t              head
);

	out_item_t              entries [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] wr_ptr_q;
	logic [OFIFO_PTR_W-1:0] rd_ptr_q;
	logic [OFIFO_CNT_W-1:0] count_q;
	logic                   pop;

	assign tvalid = (count_q != '0);
	assign pop    = tvalid && tready;
	assign head   = entries[rd_ptr_q];
	assign room   = (count_q <= OFIFO_CNT_W'(OFIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OFIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OFIFO_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + OFIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - OFIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/lzw_byte_compressor_top.sv */
// LZW byte compressor, top level: control, prefix state, config register.
// Depends on lbc_pkg, lbc_cell and lbc_out_fifo.
//
//  channel  | direction | transfer carries
//  s_axis   | in        | tdata[7:0] data_byte, tlast last_byte
//  m_axis   | out       | tdata[11:0] code (zero-filled to 16), tlast end_of_stream
//  apb      | in/out    | code_limit at byte address 0
//
// One byte at a time. The first byte of a stream skips the search. Otherwise
// R = ceil((next_free_code - 256) / CELLS) rows are swept and then the chain drains,
// all cells reading one row per cycle; an empty dictionary skips sweep and drain.
// Reset clears control state; dictionary banks need no clearing.
// Input is taken only between bytes and stalls while the result queue has fewer
// than two free slots.
module lzw_byte_compressor_top import lbc_pkg::*; #(
	parameter int CODE_BITS = 12,
	parameter int CELL_BITS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,  // [7:0] data_byte
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [11:0] code, [15:12] zero
	output logic                   m_axis_tlast,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	localparam int CELLS     = 1 << CELL_BITS;
	localparam int ROW_BITS  = CODE_BITS - CELL_BITS;
	localparam int DICT      = 1 << CODE_BITS;
	localparam int NFC_W     = CODE_BITS + 1;
	localparam int KEY_W     = CODE_BITS + BYTE_W;
	localparam int CMP_W     = (NFC_W > LIMIT_W) ? NFC_W : LIMIT_W;
	localparam logic [ROW_BITS-1:0] FIRST_ROW = ROW_BITS'(FIRST_FREE >> CELL_BITS);

	state_t               state_q, state_d;
	logic [CODE_BITS-1:0] prefix_q;
	logic                 prefix_vld_q;
	logic [NFC_W-1:0]     nfc_q;
	logic [NFC_W-1:0]     nfc_m1;
	logic [LIMIT_W-1:0]   code_limit_q;
	logic [BYTE_W-1:0]    byte_q;
	logic                 last_q;
	logic [KEY_W-1:0]     key_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [ROW_BITS-1:0]  last_row;
	logic [CELL_BITS-1:0] drain_q;

	logic                 accept;
	logic                 clear;
	logic                 rd_en;
	logic                 wr_en;
	logic                 push;
	out_item_t            push_item;
	out_item_t            head;
	logic                 room;
	logic                 grow_ok;
	logic                 dict_empty;

	logic                 hit_chain  [CELLS+1];
	logic [CODE_BITS-1:0] code_chain [CELLS+1];

	// Configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CODE_LIMIT)) begin
			code_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CODE_LIMIT) begin
			prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, code_limit_q};
		end
	end

	// Search chain
	assign nfc_m1     = nfc_q - NFC_W'(1);
	assign last_row   = nfc_m1[CODE_BITS-1:CELL_BITS];
	assign dict_empty = (nfc_q == NFC_W'(FIRST_FREE));
	assign grow_ok    = (CMP_W'(nfc_q) <= CMP_W'(code_limit_q))
	                 && (CMP_W'(nfc_q) <= CMP_W'(DICT - 1));

	assign hit_chain[0]  = 1'b0;
	assign code_chain[0] = '0;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		lbc_cell #(
			.CODE_BITS (CODE_BITS),
			.CELL_BITS (CELL_BITS),
			.CELL_IDX  (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (clear),
			.rd_en    (rd_en),
			.rd_row   (row_q),
			.wr_en    (wr_en && (nfc_q[CELL_BITS-1:0] == CELL_BITS'(k))),
			.wr_row   (nfc_q[CODE_BITS-1:CELL_BITS]),
			.wr_key   (key_q),
			.key      (key_q),
			.nfc      (nfc_q),
			.hit_in   (hit_chain[k]),
			.code_in  (code_chain[k]),
			.hit_out  (hit_chain[k+1]),
			.code_out (code_chain[k+1])
		);
	end

	// Control
	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		clear         = 1'b0;
		rd_en         = 1'b0;
		wr_en         = 1'b0;
		push          = 1'b0;
		push_item     = '{eos: 1'b0, code: CODE_W'(prefix_q)};
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = room;
				clear         = s_axis_tvalid && room;
				if (s_axis_tvalid && room) begin
					priority if (!prefix_vld_q) begin
						state_d = ST_FINISH;
					end else if (dict_empty) begin
						state_d = ST_DECIDE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (row_q == last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == CELL_BITS'(CELLS - 1)) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!hit_chain[CELLS]) begin
					push  = 1'b1;
					wr_en = grow_ok;
				end
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				push          = last_q;
				push_item.eos = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q     <= '0;
			prefix_vld_q <= 1'b0;
			nfc_q        <= NFC_W'(FIRST_FREE);
			row_q        <= '0;
			drain_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_q   <= FIRST_ROW;
						drain_q <= '0;
						if (!prefix_vld_q) begin
							prefix_q     <= CODE_BITS'(s_axis_tdata);
							prefix_vld_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					row_q <= row_q + ROW_BITS'(1);
				end
				ST_DRAIN: begin
					drain_q <= drain_q + CELL_BITS'(1);
				end
				ST_DECIDE: begin
					if (hit_chain[CELLS]) begin
						prefix_q <= code_chain[CELLS];
					end else begin
						prefix_q <= CODE_BITS'(byte_q);
						if (grow_ok) begin
							nfc_q <= nfc_q + NFC_W'(1);
						end
					end
				end
				ST_FINISH: begin
					if (last_q) begin
						prefix_q     <= '0;
						prefix_vld_q <= 1'b0;
						nfc_q        <= NFC_W'(FIRST_FREE);
					end
				end
				default: begin
					prefix_q <= prefix_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= s_axis_tdata;
			last_q <= s_axis_tlast;
			key_q  <= {prefix_q, s_axis_tdata};
		end
	end

	// Results
	lbc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.room      (room),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.head      (head)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-CODE_W){1'b0}}, head.code};
	assign m_axis_tlast = head.eos;

endmodule
